>>> src/pssim_pkg.sv
// Shared types, constants and helpers for the pairwise shared-weight similarity block.
// Used by pssim_div and pairwise_shared_weight_similarity; no dependencies.
`default_nettype none

package pssim_pkg;

    // Command codes carried on s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_THRESHOLD   = 1'b1;

    // Status codes carried on m_tuser
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    localparam int ROWS_REG_W = 7;
    localparam int THR_W      = 16;
    localparam int WORD_W     = 32;

    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [THR_W-1:0]      THR_RESET  = 16'd0;

    // Q15.16 constants and saturation limits
    localparam logic [WORD_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [WORD_W-1:0] SIM_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SIM_MIN = 32'h8000_0000;

    // Quotient bits produced by the divider once overflow is ruled out
    localparam int QUO_BITS = 31;

    // Divider result handed back to the sequencer
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_res_t;

    // Element counts as present when its magnitude is strictly above the threshold
    function automatic logic is_present(input logic signed [WORD_W-1:0] w,
                                        input logic [THR_W-1:0] thr);
        logic signed [WORD_W+1:0] wx;
        logic signed [WORD_W+1:0] tx;
        wx = (WORD_W+2)'(w);
        tx = $signed({{(WORD_W+2-THR_W){1'b0}}, thr});
        return (wx > tx) || (wx < -tx);
    endfunction

endpackage

`default_nettype wire

>>> src/pssim_store.sv
// Weight matrix storage: one write port, two registered read ports.
// Depends on nothing; instantiated by pairwise_shared_weight_similarity.
`default_nettype none

module pssim_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [31:0]       rd_data_a,
    output logic      [31:0]       rd_data_b
);

    logic [31:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> src/pssim_div.sv
// Iterative signed divider: (num * 2^16) / den, truncated toward zero, saturated to 32 bits.
// Depends on pssim_pkg; one restoring subtract per cycle, then done.
`default_nettype none

module pssim_div #(
    parameter int ACC_W = 39
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] num,   // held stable until done
    input  wire logic signed [ACC_W-1:0] den,   // nonzero, held stable until done
    output pssim_pkg::div_res_t          res
);

    typedef enum logic [1:0] {D_IDLE, D_MAG, D_CHECK, D_STEP} dstate_t;

    localparam int CNT_W = $clog2(pssim_pkg::QUO_BITS);

    dstate_t                          state_reg;
    logic [CNT_W-1:0]                 step_reg;
    logic                             done_reg;
    logic [pssim_pkg::WORD_W-1:0]     result_reg;
    logic                             neg_reg;
    logic [ACC_W-1:0]                 num_mag_reg;
    logic [ACC_W-1:0]                 den_mag_reg;
    logic [ACC_W-1:0]                 rem_reg;
    logic [pssim_pkg::QUO_BITS-1:0]   quo_reg;

    logic [ACC_W:0]                   shifted;
    logic [ACC_W:0]                   trial;
    logic [ACC_W-1:0]                 rem_next;
    logic [pssim_pkg::QUO_BITS-1:0]   quo_next;
    logic                             ovf;
    logic [pssim_pkg::WORD_W-1:0]     signed_quo;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[pssim_pkg::QUO_BITS-1]};
        trial   = shifted - {1'b0, den_mag_reg};
        if (!trial[ACC_W]) begin
            rem_next = trial[ACC_W-1:0];
            quo_next = {quo_reg[pssim_pkg::QUO_BITS-2:0], 1'b1};
        end else begin
            rem_next = shifted[ACC_W-1:0];
            quo_next = {quo_reg[pssim_pkg::QUO_BITS-2:0], 1'b0};
        end
    end

    // |num| * 2^16 >= |den| * 2^31 means the quotient leaves the 32-bit range
    assign ovf = {15'b0, num_mag_reg} >= {den_mag_reg, 15'b0};

    assign signed_quo = neg_reg ? (32'd0 - {1'b0, quo_next}) : {1'b0, quo_next};

    // Sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        state_reg <= D_MAG;
                    end
                end
                D_MAG: begin
                    num_mag_reg <= num[ACC_W-1] ? $unsigned(-num) : $unsigned(num);
                    den_mag_reg <= den[ACC_W-1] ? $unsigned(-den) : $unsigned(den);
                    neg_reg     <= num[ACC_W-1] ^ den[ACC_W-1];
                    state_reg   <= D_CHECK;
                end
                D_CHECK: begin
                    if (ovf) begin
                        result_reg <= neg_reg ? pssim_pkg::SIM_MIN : pssim_pkg::SIM_MAX;
                        done_reg   <= 1'b1;
                        state_reg  <= D_IDLE;
                    end else begin
                        rem_reg   <= ACC_W'(num_mag_reg >> 15);
                        quo_reg   <= {num_mag_reg[14:0], 16'b0};
                        step_reg  <= '0;
                        state_reg <= D_STEP;
                    end
                end
                D_STEP: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == CNT_W'(pssim_pkg::QUO_BITS - 1)) begin
                        result_reg <= signed_quo;
                        done_reg   <= 1'b1;
                        state_reg  <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = result_reg;

endmodule

`default_nettype wire

>>> src/pairwise_shared_weight_similarity.sv
// Top level of the pairwise shared-weight similarity block: command sequencer, row
// accumulation and output register. Depends on pssim_pkg, pssim_store and pssim_div.
//
// Usage:
//   s_ channel carries requests. s_tuser is the command: write stores value at
//   (row, col_a); query returns the similarity of columns col_a and col_b.
//   m_ channel returns one result per query: m_tdata is the Q15.16 similarity, m_tuser
//   the status (set on a zero denominator, no rows in use or a column out of range).
//   cfg_ channel writes rows_in_use (index 0) and nonzero_threshold (index 1);
//   it is always ready and must only be used while the block is idle.
// Sequence:
//   A write is stored on acceptance. A query of a column with itself, or with a
//   column out of range, goes straight to the output stage. A full query over N rows
//   in use takes the request, paired store reads (one row per cycle through the two
//   read ports), a drain of the store read and pair stages, the restoring divider
//   (start, setup, one quotient bit per cycle for 31 bits, done; done early when the
//   quotient saturates) and the load of the output register.
//   s_tready is low while a query is in progress.
// Reset: aresetn (synchronous) restores the registers to 64 rows and threshold 0.
//   The weight store is not cleared; every element queried must be written first.
// Stall: a finished result waits in the output register; the block keeps taking
//   writes meanwhile, and a following query holds its result until it is free.
`default_nettype none

module pairwise_shared_weight_similarity #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row[5:0], col_a[9:6], col_b[13:10], value[45:14]
    input  wire logic [0:0]  s_tuser,   // command[0]
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // similarity[31:0]
    output logic      [0:0]  m_tuser,   // status[0]
    // Configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ACC_W     = 33 + $clog2(MAX_ROWS);

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV, ST_FINISH} state_t;

    // Request fields
    logic        in_cmd;
    logic [5:0]  in_row;
    logic [3:0]  in_col_a;
    logic [3:0]  in_col_b;
    logic [31:0] in_value;

    assign in_cmd   = s_tuser[0];
    assign in_row   = s_tdata[5:0];
    assign in_col_a = s_tdata[9:6];
    assign in_col_b = s_tdata[13:10];
    assign in_value = s_tdata[45:14];

    // Configuration registers
    logic [pssim_pkg::ROWS_REG_W-1:0] rows_in_use_reg;
    logic [pssim_pkg::THR_W-1:0]      threshold_reg;

    state_t                state_reg;
    logic                  in_accept;
    logic                  out_free;
    logic [ROW_CNT_W-1:0]  nrows;
    logic [ROW_CNT_W-1:0]  nrows_reg;
    logic [ROW_CNT_W-1:0]  row_cnt_reg;
    logic [ADDR_W-1:0]     addr_a_reg;
    logic [ADDR_W-1:0]     addr_b_reg;
    logic                  rd_en;
    logic                  d1_reg;
    logic                  d2_reg;
    logic [31:0]           rd_data_a;
    logic [31:0]           rd_data_b;
    logic signed [32:0]    pair_sum_reg;
    logic                  pair_pres_reg;
    logic signed [ACC_W-1:0] num_acc_reg;
    logic signed [ACC_W-1:0] den_acc_reg;
    logic                  div_start_reg;
    pssim_pkg::div_res_t   div_res;
    logic [31:0]           res_sim_reg;
    logic                  res_stat_reg;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  col_oob;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Row count clamps to the store height
    assign nrows = (32'(rows_in_use_reg) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS)
                                                     : ROW_CNT_W'(rows_in_use_reg);

    assign col_oob = (32'(in_col_a) >= MAX_COLS) || (32'(in_col_b) >= MAX_COLS);

    // Element writes land in the store on acceptance; out-of-range ones are dropped
    assign wr_en   = in_accept && (in_cmd == pssim_pkg::CMD_WRITE)
                     && (32'(in_row) < MAX_ROWS) && (32'(in_col_a) < MAX_COLS);
    assign wr_addr = ADDR_W'(32'(in_row) * MAX_COLS + 32'(in_col_a));

    assign rd_en = (state_reg == ST_SCAN);

    pssim_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_value),
        .rd_en     (rd_en),
        .rd_addr_a (addr_a_reg),
        .rd_addr_b (addr_b_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    pssim_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_acc_reg),
        .den     (den_acc_reg),
        .res     (div_res)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= pssim_pkg::ROWS_RESET;
            threshold_reg   <= pssim_pkg::THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index[0])
                pssim_pkg::REG_ROWS_IN_USE:
                    rows_in_use_reg <= cfg_data[pssim_pkg::ROWS_REG_W-1:0];
                pssim_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pair stage: sum and presence of the two elements of one row
    always_ff @(posedge aclk) begin
        if (d1_reg) begin
            pair_sum_reg  <= 33'(signed'(rd_data_a)) + 33'(signed'(rd_data_b));
            pair_pres_reg <= pssim_pkg::is_present(signed'(rd_data_a), threshold_reg)
                             && pssim_pkg::is_present(signed'(rd_data_b), threshold_reg);
        end
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            d1_reg        <= 1'b0;
            d2_reg        <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
            row_cnt_reg   <= '0;
            nrows_reg     <= '0;
            addr_a_reg    <= '0;
            addr_b_reg    <= '0;
            num_acc_reg   <= '0;
            den_acc_reg   <= '0;
            res_sim_reg   <= '0;
            res_stat_reg  <= 1'b0;
        end else begin
            d1_reg        <= rd_en;
            d2_reg        <= d1_reg;
            div_start_reg <= 1'b0;

            // Output valid: loaded from the finish state, cleared once taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (d2_reg) begin
                den_acc_reg <= den_acc_reg + ACC_W'(pair_sum_reg);
                if (pair_pres_reg) begin
                    num_acc_reg <= num_acc_reg + ACC_W'(pair_sum_reg);
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && (in_cmd == pssim_pkg::CMD_QUERY)) begin
                        priority if (in_col_a == in_col_b) begin
                            res_sim_reg  <= pssim_pkg::Q_ONE;
                            res_stat_reg <= pssim_pkg::STAT_OK;
                            state_reg    <= ST_FINISH;
                        end else if (col_oob || (nrows == '0)) begin
                            res_sim_reg  <= '0;
                            res_stat_reg <= pssim_pkg::STAT_ERR;
                            state_reg    <= ST_FINISH;
                        end else begin
                            addr_a_reg  <= ADDR_W'(in_col_a);
                            addr_b_reg  <= ADDR_W'(in_col_b);
                            row_cnt_reg <= '0;
                            nrows_reg   <= nrows;
                            num_acc_reg <= '0;
                            den_acc_reg <= '0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                // One row of both columns read per cycle
                ST_SCAN: begin
                    addr_a_reg  <= addr_a_reg + ADDR_W'(MAX_COLS);
                    addr_b_reg  <= addr_b_reg + ADDR_W'(MAX_COLS);
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                    if (row_cnt_reg == nrows_reg - ROW_CNT_W'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                // Wait for the last row to reach the accumulators
                ST_DRAIN: begin
                    if (!d1_reg && !d2_reg) begin
                        if (den_acc_reg == '0) begin
                            res_sim_reg  <= '0;
                            res_stat_reg <= pssim_pkg::STAT_ERR;
                            state_reg    <= ST_FINISH;
                        end else begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        res_sim_reg  <= div_res.quotient;
                        res_stat_reg <= pssim_pkg::STAT_OK;
                        state_reg    <= ST_FINISH;
                    end
                end
                // Hand the result over once the output register is free
                ST_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg  <= res_sim_reg;
                        m_tuser_reg  <= res_stat_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire
